FILE: design/g2e_pkg.sv
`default_nettype none

package g2e_pkg;

   // cordic depth
   localparam int CORDIC_STAGES = 32;

   // field widths
   localparam int LAT_W = 31;
   localparam int LON_W = 32;
   localparam int HGT_W = 28;
   localparam int OUT_W = 34;
   localparam int REQ_W = 96;
   localparam int RSP_W = 104;

   // internal formats: angles and rotation vectors in q40, heights in q20 mm
   localparam int ANG_W = 44;
   localparam int HQ_W  = 48;
   localparam int MW    = 64;
   localparam int SH_W  = 6;

   localparam logic signed [ANG_W-1:0] PI_Q40         = 44'sd3454217652358;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q40    = 44'sd1727108826179;
   localparam logic signed [ANG_W-1:0] QUARTER_PI_Q40 = 44'sd863554413089;
   localparam logic signed [ANG_W-1:0] GAIN_Q40       = 44'sd667681663043;

   localparam logic [MW-1:0] E2_Q60           = 64'd7360548655 << 20;
   localparam logic [MW-1:0] ONE_MINUS_E2_Q60 = (64'd1 << 60) - E2_Q60;
   localparam logic [MW-1:0] A_MM             = 64'd6378137000;

   // series coefficients for 1/sqrt(1-u), q60
   localparam logic [MW-1:0] SER_C5 = 64'd63 << 52;
   localparam logic [MW-1:0] SER_C4 = 64'd35 << 53;
   localparam logic [MW-1:0] SER_C3 = 64'd5 << 56;
   localparam logic [MW-1:0] SER_C2 = 64'd3 << 57;
   localparam logic [MW-1:0] SER_C1 = 64'd1 << 59;
   localparam logic [MW-1:0] SER_C0 = 64'd1 << 60;

   localparam logic [SH_W-1:0] SH_Q20 = 6'd20;
   localparam logic [SH_W-1:0] SH_Q40 = 6'd40;
   localparam logic [SH_W-1:0] SH_Q60 = 6'd60;

   // one cordic channel
   typedef struct packed {
      logic signed [ANG_W-1:0] x;
      logic signed [ANG_W-1:0] y;
      logic signed [ANG_W-1:0] z;
      logic                    neg;
   } g2e_rot_type;

   // values riding alongside the arithmetic pipeline
   typedef struct packed {
      logic signed [ANG_W-1:0] sb;
      logic signed [ANG_W-1:0] cb;
      logic signed [ANG_W-1:0] sl;
      logic signed [ANG_W-1:0] cl;
      logic signed [HQ_W-1:0]  h_q20;
      logic [MW-1:0]           u;
      logic [MW-1:0]           n;
      logic [MW-1:0]           zmag;
      logic                    ncb_neg;
      logic                    zneg;
   } g2e_side_type;

   // restoring division, elaboration only
   function automatic logic [MW-1:0] udiv64(input logic [MW-1:0] num,
                                            input logic [MW-1:0] den);
      logic [MW:0]   rem;
      logic [MW-1:0] quo;
      rem = '0;
      quo = '0;
      for (int b = MW - 1; b >= 0; b--) begin
         rem = {rem[MW-1:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(2^-i) in q40, series summed in q62
   function automatic logic signed [ANG_W-1:0] atan_q40(input int i);
      logic signed [MW-1:0] acc;
      logic [MW-1:0]        term;
      acc = '0;
      if (i == 0) begin
         return QUARTER_PI_Q40;
      end
      for (int k = 0; k < 32; k++) begin
         if (i * (2 * k + 1) <= 62) begin
            term = udiv64(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
            if (k % 2 == 1) begin
               acc = acc - signed'(term);
            end else begin
               acc = acc + signed'(term);
            end
         end
      end
      return ANG_W'((acc + 64'sd2097152) >>> 22);
   endfunction

endpackage

`default_nettype wire

FILE: design/g2e_mul.sv
`default_nettype none

// floor(a*b >> sh) + add, three stages: partial products, sum, shift and add
module g2e_mul import g2e_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            vld_i,
   input  wire logic [MW-1:0]   a_i,
   input  wire logic [MW-1:0]   b_i,
   input  wire logic [SH_W-1:0] sh_i,
   input  wire logic [MW-1:0]   add_i,
   input  wire g2e_side_type    side_i,
   output logic                 vld_o,
   output logic [MW-1:0]        p_o,
   output g2e_side_type         side_o
);

   localparam int HW = MW / 2;

   logic [MW-1:0]   pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   logic [SH_W-1:0] sh1_ff, sh2_ff;
   logic [MW-1:0]   add1_ff, add2_ff;
   g2e_side_type    side1_ff, side2_ff, side3_ff;
   logic            vld1_ff, vld2_ff, vld3_ff;
   logic [2*MW-1:0] prod_ff, prod_in;
   logic [MW-1:0]   p_ff, p_in;

   assign prod_in = {pp11_ff, pp00_ff}
                  + ({{MW{1'b0}}, pp01_ff} << HW)
                  + ({{MW{1'b0}}, pp10_ff} << HW);
   assign p_in    = MW'(prod_ff >> sh2_ff) + add2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pp00_ff  <= MW'(a_i[HW-1:0]) * MW'(b_i[HW-1:0]);
         pp01_ff  <= MW'(a_i[HW-1:0]) * MW'(b_i[MW-1:HW]);
         pp10_ff  <= MW'(a_i[MW-1:HW]) * MW'(b_i[HW-1:0]);
         pp11_ff  <= MW'(a_i[MW-1:HW]) * MW'(b_i[MW-1:HW]);
         sh1_ff   <= sh_i;
         add1_ff  <= add_i;
         side1_ff <= side_i;
         prod_ff  <= prod_in;
         sh2_ff   <= sh1_ff;
         add2_ff  <= add1_ff;
         side2_ff <= side1_ff;
         p_ff     <= p_in;
         side3_ff <= side2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= vld_i;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   assign vld_o  = vld3_ff;
   assign p_o    = p_ff;
   assign side_o = side3_ff;

endmodule

`default_nettype wire

FILE: design/g2e_cordic.sv
`default_nettype none

// latitude and longitude rotation cordic, one register stage per iteration
module g2e_cordic import g2e_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire logic                    vld_i,
   input  wire logic signed [LAT_W-1:0] lat_i,
   input  wire logic signed [LON_W-1:0] lon_i,
   input  wire g2e_side_type            side_i,
   output logic                         vld_o,
   output g2e_rot_type                  lat_o,
   output g2e_rot_type                  lon_o,
   output g2e_side_type                 side_o
);

   g2e_rot_type  lat_ff  [CORDIC_STAGES+1];
   g2e_rot_type  lon_ff  [CORDIC_STAGES+1];
   g2e_side_type side_ff [CORDIC_STAGES+1];
   logic         vld_ff  [CORDIC_STAGES+1];
   g2e_rot_type  lat_in, lon_in;

   // fold into +-pi/2, remember to negate at the end
   function automatic g2e_rot_type fold(input logic signed [ANG_W-1:0] ang);
      g2e_rot_type r;
      r.x   = GAIN_Q40;
      r.y   = '0;
      r.z   = ang;
      r.neg = 1'b0;
      if (ang > HALF_PI_Q40) begin
         r.z   = ang - PI_Q40;
         r.neg = 1'b1;
      end else if (ang < -HALF_PI_Q40) begin
         r.z   = ang + PI_Q40;
         r.neg = 1'b1;
      end
      return r;
   endfunction

   function automatic g2e_rot_type rot_step(input g2e_rot_type r, input int sh,
                                            input logic signed [ANG_W-1:0] at);
      g2e_rot_type             o;
      logic signed [ANG_W-1:0] dx, dy;
      dx    = r.y >>> sh;
      dy    = r.x >>> sh;
      o.neg = r.neg;
      if (r.z >= 0) begin
         o.x = r.x - dx;
         o.y = r.y + dy;
         o.z = r.z - at;
      end else begin
         o.x = r.x + dx;
         o.y = r.y - dy;
         o.z = r.z + at;
      end
      return o;
   endfunction

   assign lat_in = fold(ANG_W'(lat_i) <<< 11);
   assign lon_in = fold(ANG_W'(lon_i) <<< 11);

   always_ff @(posedge clock) begin
      if (en) begin
         lat_ff[0]  <= lat_in;
         lon_ff[0]  <= lon_in;
         side_ff[0] <= side_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= vld_i;
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      localparam logic signed [ANG_W-1:0] AT = atan_q40(i);

      always_ff @(posedge clock) begin
         if (en) begin
            lat_ff[i+1]  <= rot_step(lat_ff[i], i, AT);
            lon_ff[i+1]  <= rot_step(lon_ff[i], i, AT);
            side_ff[i+1] <= side_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end
   end

   assign vld_o  = vld_ff[CORDIC_STAGES];
   assign lat_o  = lat_ff[CORDIC_STAGES];
   assign lon_o  = lon_ff[CORDIC_STAGES];
   assign side_o = side_ff[CORDIC_STAGES];

endmodule

`default_nettype wire

FILE: design/geodetic_to_ecef.sv
`default_nettype none

// wgs84 geodetic to ecef converter. each request word carries latitude and
// longitude in radians (signed, 29 fraction bits) and ellipsoidal height in mm;
// each response word carries x, y and z in mm, rounded to nearest. one word
// can be taken every cycle while the output is not stalled. a word passes a
// fold stage, 32 cordic stages, a trig stage, nine multipliers for sin^2,
// the 1/sqrt series, n and n(1-e2), a sum stage, two more multiplier ranks
// and a rounding stage that is also the output register. the whole pipeline
// advances together whenever the output register is empty or being read, so
// a stall on the response side holds every word in place and loses nothing.
module geodetic_to_ecef import g2e_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // latitude[30:0], longitude[62:31], height_mm[90:63], zero pad
   input  wire logic [REQ_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // ecef_x_mm[33:0], ecef_y_mm[67:34], ecef_z_mm[101:68], zero pad
   output logic [RSP_W-1:0]      rsp_tdata
);

   logic         adv;
   g2e_side_type side_entry;

   // cordic
   logic         cor_vld;
   g2e_rot_type  cor_lat, cor_lon;
   g2e_side_type cor_side;

   // trig stage
   logic         trig_vld_ff;
   g2e_side_type trig_side_ff, trig_side_in;

   // multiplier chain
   logic         m_vld  [11];
   logic [MW-1:0] m_p   [11];
   g2e_side_type m_side [11];
   g2e_side_type m3_side_in, m9_side_in, m11_side_in;
   logic         m10b_vld_nc, m11b_vld_nc;
   g2e_side_type m10b_side_nc, m11b_side_nc;
   logic [MW-1:0] zmul_p, ymul_p;

   // sum stage
   logic                 sum_vld_ff;
   g2e_side_type         sum_side_ff;
   logic [MW-1:0]        nh_mag_ff, nzh_mag_ff;
   logic                 nh_neg_ff, nzh_neg_ff;
   logic signed [MW-1:0] nh_in, nzh_in;
   g2e_side_type         m10_side_in;

   // output register
   logic                 rsp_vld_ff;
   logic [RSP_W-1:0]     rsp_data_ff, rsp_data_in;

   function automatic logic [MW-1:0] ang_mag(input logic signed [ANG_W-1:0] v);
      logic signed [ANG_W-1:0] nv;
      nv = -v;
      return v[ANG_W-1] ? MW'(nv) : MW'(v);
   endfunction

   function automatic logic [MW-1:0] wide_mag(input logic signed [MW-1:0] v);
      logic signed [MW-1:0] nv;
      nv = -v;
      return v[MW-1] ? nv : v;
   endfunction

   // magnitude in q20 mm to whole mm, half away from zero
   function automatic logic [OUT_W-1:0] round_mm(input logic [MW-1:0] p,
                                                 input logic neg);
      logic [MW-1:0] m;
      m = (p + (64'd1 << 19)) >> 20;
      return neg ? OUT_W'(-m) : OUT_W'(m);
   endfunction

   // the pipeline moves as one
   assign adv        = !rsp_vld_ff || rsp_tready;
   assign req_tready = adv;

   always_comb begin
      side_entry       = '0;
      side_entry.h_q20 = HQ_W'(signed'(req_tdata[90:63])) <<< 20;
   end

   g2e_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .en     (adv),
      .vld_i  (req_tvalid),
      .lat_i  (req_tdata[30:0]),
      .lon_i  (req_tdata[62:31]),
      .side_i (side_entry),
      .vld_o  (cor_vld),
      .lat_o  (cor_lat),
      .lon_o  (cor_lon),
      .side_o (cor_side)
   );

   // undo the fold: negate sine and cosine
   always_comb begin
      trig_side_in    = cor_side;
      trig_side_in.sb = cor_lat.neg ? -cor_lat.y : cor_lat.y;
      trig_side_in.cb = cor_lat.neg ? -cor_lat.x : cor_lat.x;
      trig_side_in.sl = cor_lon.neg ? -cor_lon.y : cor_lon.y;
      trig_side_in.cl = cor_lon.neg ? -cor_lon.x : cor_lon.x;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         trig_side_ff <= trig_side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_vld_ff <= 1'b0;
      end else if (adv) begin
         trig_vld_ff <= cor_vld;
      end
   end

   // s2 = sin^2 lat, q60
   g2e_mul u_m_s2 (
      .clock (clock), .reset (reset), .en (adv), .vld_i (trig_vld_ff),
      .a_i (ang_mag(trig_side_ff.sb)), .b_i (ang_mag(trig_side_ff.sb)),
      .sh_i (SH_Q20), .add_i ('0), .side_i (trig_side_ff),
      .vld_o (m_vld[0]), .p_o (m_p[0]), .side_o (m_side[0])
   );

   // u = e2 * s2
   g2e_mul u_m_u (
      .clock (clock), .reset (reset), .en (adv), .vld_i (m_vld[0]),
      .a_i (E2_Q60), .b_i (m_p[0]), .sh_i (SH_Q60), .add_i ('0),
      .side_i (m_side[0]),
      .vld_o (m_vld[1]), .p_o (m_p[1]), .side_o (m_side[1])
   );

   always_comb begin
      m3_side_in   = m_side[1];
      m3_side_in.u = m_p[1];
   end

   // horner steps of the series for 1/sqrt(1-u)
   g2e_mul u_m_f4 (
      .clock (clock), .reset (reset), .en (adv), .vld_i (m_vld[1]),
      .a_i (m_p[1]), .b_i (SER_C5), .sh_i (SH_Q60), .add_i (SER_C4),
      .side_i (m3_side_in),
      .vld_o (m_vld[2]), .p_o (m_p[2]), .side_o (m_side[2])
   );

   g2e_mul u_m_f3 (
      .clock (clock), .reset (reset), .en (adv), .vld_i (m_vld[2]),
      .a_i (m_side[2].u), .b_i (m_p[2]), .sh_i (SH_Q60), .add_i (SER_C3),
      .side_i (m_side[2]),
      .vld_o (m_vld[3]), .p_o (m_p[3]), .side_o (m_side[3])
   );

   g2e_mul u_m_f2 (
      .clock (clock), .reset (reset), .en (adv), .vld_i (m_vld[3]),
      .a_i (m_side[3].u), .b_i (m_p[3]), .sh_i (SH_Q60), .add_i (SER_C2),
      .side_i (m_side[3]),
      .vld_o (m_vld[4]), .p_o (m_p[4]), .side_o (m_side[4])
   );

   g2e_mul u_m_f1 (
      .clock (clock), .reset (reset), .en (adv), .vld_i (m_vld[4]),
      .a_i (m_side[4].u), .b_i (m_p[4]), .sh_i (SH_Q60), .add_i (SER_C1),
      .side_i (m_side[4]),
      .vld_o (m_vld[5]), .p_o (m_p[5]), .side_o (m_side[5])
   );

   g2e_mul u_m_f0 (
      .clock (clock), .reset (reset), .en (adv), .vld_i (m_vld[5]),
      .a_i (m_side[5].u), .b_i (m_p[5]), .sh_i (SH_Q60), .add_i (SER_C0),
      .side_i (m_side[5]),
      .vld_o (m_vld[6]), .p_o (m_p[6]), .side_o (m_side[6])
   );

   // n = a * f, q20 mm
   g2e_mul u_m_n (
      .clock (clock), .reset (reset), .en (adv), .vld_i (m_vld[6]),
      .a_i (A_MM), .b_i (m_p[6]), .sh_i (SH_Q40), .add_i ('0),
      .side_i (m_side[6]),
      .vld_o (m_vld[7]), .p_o (m_p[7]), .side_o (m_side[7])
   );

   always_comb begin
      m9_side_in   = m_side[7];
      m9_side_in.n = m_p[7];
   end

   // n(1-e2)
   g2e_mul u_m_nz (
      .clock (clock), .reset (reset), .en (adv), .vld_i (m_vld[7]),
      .a_i (m_p[7]), .b_i (ONE_MINUS_E2_Q60), .sh_i (SH_Q60), .add_i ('0),
      .side_i (m9_side_in),
      .vld_o (m_vld[8]), .p_o (m_p[8]), .side_o (m_side[8])
   );

   // add height, split into sign and magnitude
   assign nh_in  = signed'(m_side[8].n) + MW'(m_side[8].h_q20);
   assign nzh_in = signed'(m_p[8]) + MW'(m_side[8].h_q20);

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_side_ff <= m_side[8];
         nh_mag_ff   <= wide_mag(nh_in);
         nh_neg_ff   <= nh_in[MW-1];
         nzh_mag_ff  <= wide_mag(nzh_in);
         nzh_neg_ff  <= nzh_in[MW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_vld_ff <= 1'b0;
      end else if (adv) begin
         sum_vld_ff <= m_vld[8];
      end
   end

   always_comb begin
      m10_side_in         = sum_side_ff;
      m10_side_in.ncb_neg = nh_neg_ff ^ sum_side_ff.cb[ANG_W-1];
      m10_side_in.zneg    = nzh_neg_ff ^ sum_side_ff.sb[ANG_W-1];
   end

   // (n+h) cos lat
   g2e_mul u_m_ncb (
      .clock (clock), .reset (reset), .en (adv), .vld_i (sum_vld_ff),
      .a_i (nh_mag_ff), .b_i (ang_mag(sum_side_ff.cb)), .sh_i (SH_Q40),
      .add_i ('0), .side_i (m10_side_in),
      .vld_o (m_vld[9]), .p_o (m_p[9]), .side_o (m_side[9])
   );

   // (n(1-e2)+h) sin lat
   g2e_mul u_m_z (
      .clock (clock), .reset (reset), .en (adv), .vld_i (sum_vld_ff),
      .a_i (nzh_mag_ff), .b_i (ang_mag(sum_side_ff.sb)), .sh_i (SH_Q40),
      .add_i ('0), .side_i (m10_side_in),
      .vld_o (m10b_vld_nc), .p_o (zmul_p), .side_o (m10b_side_nc)
   );

   always_comb begin
      m11_side_in      = m_side[9];
      m11_side_in.zmag = zmul_p;
   end

   // x and y
   g2e_mul u_m_x (
      .clock (clock), .reset (reset), .en (adv), .vld_i (m_vld[9]),
      .a_i (m_p[9]), .b_i (ang_mag(m_side[9].cl)), .sh_i (SH_Q40),
      .add_i ('0), .side_i (m11_side_in),
      .vld_o (m_vld[10]), .p_o (m_p[10]), .side_o (m_side[10])
   );

   g2e_mul u_m_y (
      .clock (clock), .reset (reset), .en (adv), .vld_i (m_vld[9]),
      .a_i (m_p[9]), .b_i (ang_mag(m_side[9].sl)), .sh_i (SH_Q40),
      .add_i ('0), .side_i (m11_side_in),
      .vld_o (m11b_vld_nc), .p_o (ymul_p), .side_o (m11b_side_nc)
   );

   // rounding into the output register
   always_comb begin
      rsp_data_in          = '0;
      rsp_data_in[33:0]    = round_mm(m_p[10],
                                      m_side[10].ncb_neg ^ m_side[10].cl[ANG_W-1]);
      rsp_data_in[67:34]   = round_mm(ymul_p,
                                      m_side[10].ncb_neg ^ m_side[10].sl[ANG_W-1]);
      rsp_data_in[101:68]  = round_mm(m_side[10].zmag, m_side[10].zneg);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= m_vld[10];
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: design/g2e_checker.sv
`default_nettype none

module g2e_checker import g2e_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic [REQ_W-1:0] req_tdata,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata
);

   // a stalled word stays offered
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response word dropped while stalled");

   // and keeps its data
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // an empty output stage never blocks the input
   a_ready_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");

   // reset empties the pipeline
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response word right after reset");

   // pad bits stay zero
   a_pad_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_W-1:102] == '0)
      else $error("response pad bits set");

endmodule

bind geodetic_to_ecef g2e_checker u_g2e_checker (.*);

`default_nettype wire
